[design/tsd_pkg.sv]
// Shared types and constants for the timestamp delta decoder.
// No dependencies; every other design file imports this package.
package tsd_pkg;

  localparam int TS_W    = 64;
  localparam int SEC_W   = 45;
  localparam int US_W    = 30;
  localparam int SLOT_W  = 21;
  localparam int WORD_W  = 32;
  localparam int DELTA_W = 28;
  localparam int CNT_W   = 4;
  localparam int ERR_W   = 2;
  localparam int LVL_W   = 2;
  localparam int DAY_W   = 17;
  localparam int REM_W   = 20;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_WORD  = 1'b1;

  localparam logic [LVL_W-1:0] LVL_DAYS = 2'd0;
  localparam logic [LVL_W-1:0] LVL_SECS = 2'd1;
  localparam logic [LVL_W-1:0] LVL_US   = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ZERO_US = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERRUN = 2'd2;

  localparam logic [US_W-1:0]  US_PER_SEC   = 30'd1000000;
  localparam logic [DAY_W-1:0] SECS_PER_DAY = 17'd86400;

  // 2^63 = US_PER_SEC * BIAS_SECS + BIAS_US
  localparam logic [SEC_W-1:0] BIAS_SECS = 45'd9223372036854;
  localparam logic [REM_W-1:0] BIAS_US   = 20'd775808;

  typedef struct packed {
    logic               cmd;
    logic [TS_W-1:0]    start_ts;
    logic [SLOT_W-1:0]  length;
    logic [SLOT_W-1:0]  nulls;
    logic [DELTA_W-1:0] delta;
    logic [SEC_W-1:0]   day_step;
    logic [CNT_W-1:0]   count;
  } op_t;

  typedef struct packed {
    logic start;
    logic ack;
  } div_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } div_stat_t;

endpackage

[design/tsd_front.sv]
// Front end: accepts input transactions, classifies them and precomputes
// the day step and the saturated record length. Depends on tsd_pkg.
module tsd_front #(
  parameter int MAX_SLOTS = 1048576
) (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic signed [tsd_pkg::TS_W-1:0]   start_us,
  input  logic [tsd_pkg::SLOT_W-1:0]        total_length,
  input  logic [tsd_pkg::SLOT_W-1:0]        null_count,
  input  logic [tsd_pkg::WORD_W-1:0]        value_word,
  input  logic                              fifo_full,
  output logic                              push,
  output tsd_pkg::op_t                      op
);
  import tsd_pkg::*;

  localparam logic [31:0] MAX_LIM = 32'(MAX_SLOTS);

  logic [31:0]        len_wide;
  logic [SLOT_W-1:0]  len_sat;
  logic [DELTA_W-1:0] delta;

  assign in_stall = fifo_full;
  assign push     = in_valid & ~fifo_full;

  assign len_wide = {{(32 - SLOT_W){1'b0}}, total_length};
  assign len_sat  = (len_wide > MAX_LIM) ? MAX_LIM[SLOT_W-1:0] : total_length;
  assign delta    = value_word[WORD_W-1:CNT_W];

  always_comb begin
    op.cmd      = command;
    op.start_ts = start_us;
    op.length   = len_sat;
    op.nulls    = null_count;
    op.delta    = delta;
    // days level step, worked out before the queue to keep the back end short
    op.day_step = {{(SEC_W - DELTA_W){1'b0}}, delta}
                * {{(SEC_W - DAY_W){1'b0}}, SECS_PER_DAY};
    op.count    = value_word[CNT_W-1:0];
  end

endmodule

[design/tsd_fifo.sv]
// Short queue between front and back end, register based.
// Depends on tsd_pkg for the entry type and depth.
module tsd_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tsd_pkg::op_t wr_op,
  output logic         full,
  input  logic         pop,
  output tsd_pkg::op_t rd_op,
  output logic         not_empty
);
  import tsd_pkg::*;

  op_t              entry [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == (PTR_W + 1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign rd_op     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= wr_op;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W + 1)'(FIFO_DEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - 1'b1)
    else $error("pop did not drain the queue");

endmodule

[design/tsd_div.sv]
// Splits a signed microsecond start time into floored seconds and micros
// by reciprocal multiplication, one 16-bit quotient digit per MUL/SUB pass.
// Depends on tsd_pkg.
module tsd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  tsd_pkg::div_ctrl_t          ctrl,
  input  logic [tsd_pkg::TS_W-1:0]    start_ts,
  output tsd_pkg::div_stat_t          stat,
  output logic [tsd_pkg::SEC_W-1:0]   seconds,
  output logic [tsd_pkg::US_W-1:0]    micros
);
  import tsd_pkg::*;

  localparam logic [1:0] DIV_IDLE = 2'd0;
  localparam logic [1:0] DIV_MUL  = 2'd1;
  localparam logic [1:0] DIV_SUB  = 2'd2;
  localparam logic [1:0] DIV_DONE = 2'd3;

  // 10^6 = 2^6 * 15625: the low six bits go straight to the remainder and
  // the rest is divided by 15625 in 16-bit digits, top digit first
  localparam int LOW_W   = 6;
  localparam int ODD_W   = REM_W - LOW_W;
  localparam int DIGIT_W = 16;
  localparam int X_W     = ODD_W + DIGIT_W;
  localparam int RCP_W   = 31;
  localparam int RCP_SH  = 44;
  localparam int PROD_W  = X_W + RCP_W;
  localparam int IDX_W   = 2;

  localparam logic [ODD_W-1:0] ODD_DIV  = 14'd15625;
  // ceil(2^44 / 15625): exact quotient for every partial dividend below 2^30
  localparam logic [RCP_W-1:0] RECIP    = 31'd1125899907;
  localparam logic [IDX_W-1:0] IDX_LAST = '1;
  localparam logic [REM_W:0]   DIVISOR  = (REM_W + 1)'(US_PER_SEC);

  logic [1:0]         state;
  logic [TS_W-1:0]    digits;
  logic [LOW_W-1:0]   low;
  logic [ODD_W-1:0]   part;
  logic [X_W-1:0]     x;
  logic [DIGIT_W-1:0] qd;
  logic [TS_W-1:0]    quo;
  logic [IDX_W-1:0]   idx;
  logic [TS_W-1:0]    biased;
  logic [X_W-1:0]     x_in;
  logic [PROD_W-1:0]  prod;
  logic [X_W-1:0]     back;
  logic [X_W-1:0]     part_next;
  logic [REM_W-1:0]   rem;
  logic [REM_W:0]     us_wrap;

  // bias by 2^63 so the dividend is unsigned
  assign biased    = {~start_ts[TS_W-1], start_ts[TS_W-2:0]};
  assign x_in      = {part, digits[TS_W-1 -: DIGIT_W]};
  assign prod      = {{RCP_W{1'b0}}, x_in} * {{X_W{1'b0}}, RECIP};
  assign back      = {{(X_W - DIGIT_W){1'b0}}, qd} * {{(X_W - ODD_W){1'b0}}, ODD_DIV};
  assign part_next = x - back;
  assign rem       = {part, low};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      unique case (state)
        DIV_IDLE: if (ctrl.start) state <= DIV_MUL;
        DIV_MUL:  state <= DIV_SUB;
        DIV_SUB: begin
          if (idx == IDX_LAST) state <= DIV_DONE;
          else state <= DIV_MUL;
        end
        DIV_DONE: if (ctrl.ack) state <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && ctrl.start) begin
      digits <= {{LOW_W{1'b0}}, biased[TS_W-1:LOW_W]};
      low    <= biased[LOW_W-1:0];
      part   <= '0;
      quo    <= '0;
      idx    <= '0;
    end else if (state == DIV_MUL) begin
      x  <= x_in;
      qd <= prod[RCP_SH +: DIGIT_W];
    end else if (state == DIV_SUB) begin
      // remainder of the digit stays below 15625
      part   <= part_next[ODD_W-1:0];
      quo    <= {quo[TS_W-DIGIT_W-1:0], qd};
      digits <= {digits[TS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      idx    <= idx + 1'b1;
    end
  end

  // remove the bias: subtract BIAS_SECS and BIAS_US, borrow one second
  assign us_wrap = {1'b0, rem} + DIVISOR - {1'b0, BIAS_US};

  always_comb begin
    if (rem >= BIAS_US) begin
      seconds = quo[SEC_W-1:0] - BIAS_SECS;
      micros  = US_W'(rem - BIAS_US);
    end else begin
      seconds = quo[SEC_W-1:0] - BIAS_SECS - 1'b1;
      micros  = US_W'(us_wrap);
    end
  end

  assign stat.idle = (state == DIV_IDLE);
  assign stat.done = (state == DIV_DONE);

endmodule

[design/tsd_back.sv]
// Back end: runs the level cascade on queued transactions, drives the
// divider for start items and holds the output register. Depends on tsd_pkg.
module tsd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              not_empty,
  input  tsd_pkg::op_t                      head,
  output logic                              pop,
  output tsd_pkg::div_ctrl_t                div_ctrl,
  input  tsd_pkg::div_stat_t                div_stat,
  input  logic [tsd_pkg::SEC_W-1:0]         div_seconds,
  input  logic [tsd_pkg::US_W-1:0]          div_micros,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tsd_pkg::SEC_W-1:0]  epoch_seconds,
  output logic [tsd_pkg::US_W-1:0]          micros,
  output logic [tsd_pkg::CNT_W-1:0]         repeat_count,
  output logic [tsd_pkg::SLOT_W-1:0]        first_slot,
  output logic                              record_done,
  output logic [tsd_pkg::ERR_W-1:0]         error_code
);
  import tsd_pkg::*;

  logic [LVL_W-1:0]  level;
  logic [SEC_W-1:0]  seconds_acc;
  logic [US_W-1:0]   micros_acc;
  logic [SLOT_W-1:0] slot_index;
  logic [SLOT_W-1:0] record_length;

  logic [LVL_W-1:0]  level_next;
  logic [SEC_W-1:0]  seconds_next;
  logic [US_W-1:0]   micros_next;
  logic [SLOT_W-1:0] slot_next;

  logic              head_start;
  logic              head_word;
  logic              out_free;
  logic              word_go;
  logic              active;
  logic              emit;
  logic [ERR_W-1:0]  err;
  logic [SEC_W-1:0]  addend;
  logic [US_W-1:0]   us_sum;
  logic [US_W-1:0]   us_adj;
  logic              carry;
  logic [SLOT_W:0]   slot_sum;
  logic              overrun;

  logic [SEC_W-1:0]  out_seconds;

  assign head_start = not_empty & (head.cmd == CMD_START);
  assign head_word  = not_empty & (head.cmd == CMD_WORD);
  assign out_free   = ~out_valid | ~out_stall;
  assign word_go    = head_word & out_free;
  assign active     = (slot_index < record_length);

  assign div_ctrl.start = head_start & div_stat.idle;
  assign div_ctrl.ack   = head_start & div_stat.done;
  assign pop            = div_ctrl.ack | word_go;

  assign us_sum  = micros_acc + US_W'(head.delta);
  assign carry   = (us_sum >= US_PER_SEC);
  assign us_adj  = carry ? (us_sum - US_PER_SEC) : us_sum;
  assign slot_sum = {1'b0, slot_index} + (SLOT_W + 1)'(head.count);
  assign overrun  = (slot_sum > {1'b0, record_length});

  always_comb begin
    micros_next = micros_acc;
    unique case (level)
      LVL_DAYS: addend = head.day_step;
      LVL_SECS: addend = SEC_W'(head.delta);
      default: begin
        addend      = SEC_W'(carry);
        micros_next = us_adj;
      end
    endcase
    seconds_next = seconds_acc + addend;

    emit       = 1'b0;
    err        = ERR_NONE;
    slot_next  = slot_index;
    level_next = level + 1'b1;
    priority if (head.count != '0) begin
      emit       = 1'b1;
      err        = overrun ? ERR_OVERRUN : ERR_NONE;
      slot_next  = overrun ? record_length : slot_sum[SLOT_W-1:0];
      level_next = LVL_DAYS;
    end else if (level != LVL_DAYS && level != LVL_SECS) begin
      emit       = 1'b1;
      err        = ERR_ZERO_US;
      slot_next  = record_length;
      level_next = LVL_DAYS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= LVL_DAYS;
      seconds_acc   <= '0;
      micros_acc    <= '0;
      slot_index    <= '0;
      record_length <= '0;
    end else if (div_ctrl.ack) begin
      level         <= LVL_DAYS;
      seconds_acc   <= div_seconds;
      micros_acc    <= div_micros;
      slot_index    <= head.nulls;
      record_length <= head.length;
    end else if (word_go && active) begin
      level       <= level_next;
      seconds_acc <= seconds_next;
      micros_acc  <= micros_next;
      slot_index  <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word_go && active && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_go && active && emit) begin
      out_seconds  <= seconds_next;
      micros       <= micros_next;
      repeat_count <= head.count;
      first_slot   <= slot_index;
      record_done  <= (slot_next >= record_length);
      error_code   <= err;
    end
  end

  assign epoch_seconds = $signed(out_seconds);

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_US)
    else $error("cascade level out of range");

  a_zero_us_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == ERR_ZERO_US) |-> repeat_count == '0)
    else $error("zero-count error with a nonzero repeat count");

  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_NONE) |-> record_done)
    else $error("error result without record end");

  a_start_waits: assert property (@(posedge clk) disable iff (rst)
    (pop && head_start) |-> div_stat.done)
    else $error("start item popped before the split finished");

endmodule

[design/timestamp_delta_decoder.sv]
// Top level of the timestamp delta decoder: front end, queue, start-time
// divider and back end. Depends on tsd_pkg, tsd_front, tsd_fifo, tsd_div, tsd_back.
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   input    in_valid / in_stall  command, start_us, total_length,
//                                 null_count, value_word
//   output   out_valid/out_stall  epoch_seconds, micros, repeat_count,
//                                 first_slot, record_done, error_code
//
// Flow: value words stream through the back end at one per cycle while the
//   output is not stalled; a result passes through the queue entry and the
//   output register before it is offered.
// A start item holds the back end until its split is done, by reciprocal
//   multiplication: one 16-bit quotient digit per divider MUL/SUB pass.
// Reset: rst, synchronous; clears queue, divider, cascade state and output.
//   No clearing pass follows.
// Stalls: out_stall holds the output register and, once the queue fills,
//   raises in_stall; the four-entry queue lets both sides stall on their own.
module timestamp_delta_decoder #(
  parameter int MAX_SLOTS = 1048576
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic signed [tsd_pkg::TS_W-1:0]   start_us,
  input  logic [tsd_pkg::SLOT_W-1:0]        total_length,
  input  logic [tsd_pkg::SLOT_W-1:0]        null_count,
  input  logic [tsd_pkg::WORD_W-1:0]        value_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tsd_pkg::SEC_W-1:0]  epoch_seconds,
  output logic [tsd_pkg::US_W-1:0]          micros,
  output logic [tsd_pkg::CNT_W-1:0]         repeat_count,
  output logic [tsd_pkg::SLOT_W-1:0]        first_slot,
  output logic                              record_done,
  output logic [tsd_pkg::ERR_W-1:0]         error_code
);
  import tsd_pkg::*;

  // front to queue
  logic      push;
  logic      fifo_full;
  op_t       wr_op;

  // queue to back end
  logic      pop;
  logic      not_empty;
  op_t       head_op;

  // back end to divider
  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [SEC_W-1:0] div_seconds;
  logic [US_W-1:0]  div_micros;

  // classify the transaction, saturate the length, form the day step
  tsd_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .start_us        (start_us),
    .total_length    (total_length),
    .null_count      (null_count),
    .value_word      (value_word),
    .fifo_full       (fifo_full),
    .push            (push),
    .op              (wr_op)
  );

  // decouple acceptance from execution
  tsd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_op     (wr_op),
    .full      (fifo_full),
    .pop       (pop),
    .rd_op     (head_op),
    .not_empty (not_empty)
  );

  // floored split of the start time; loads from the queue head on start
  tsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .start_ts (head_op.start_ts),
    .stat     (div_stat),
    .seconds  (div_seconds),
    .micros   (div_micros)
  );

  // level cascade, slot tracking and output register
  tsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .not_empty     (not_empty),
    .head          (head_op),
    .pop           (pop),
    .div_ctrl      (div_ctrl),
    .div_stat      (div_stat),
    .div_seconds   (div_seconds),
    .div_micros    (div_micros),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_seconds (epoch_seconds),
    .micros        (micros),
    .repeat_count  (repeat_count),
    .first_slot    (first_slot),
    .record_done   (record_done),
    .error_code    (error_code)
  );

endmodule

[tb/sv/tb_timestamp_delta_decoder.sv]
// Testbench for timestamp_delta_decoder: directed and random records checked
// against an in-bench decoder of the delta cascade. Depends on tsd_pkg and the RTL.
module tb_timestamp_delta_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import tsd_pkg::*;

  localparam int MAX_SLOTS = 1048576;
  localparam longint USEC_PER_SEC = 1000000;
  localparam int HOLD_CYCLES = 400;

  // One decoded timestamp as it leaves the block.
  typedef struct packed {
    logic signed [SEC_W-1:0] secs;
    logic [US_W-1:0]         usec;
    logic [CNT_W-1:0]        reps;
    logic [SLOT_W-1:0]       first;
    logic                    done;
    logic [ERR_W-1:0]        err;
  } stamp_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     command = CMD_START;
  logic signed [TS_W-1:0]   start_us = '0;
  logic [SLOT_W-1:0]        total_length = '0;
  logic [SLOT_W-1:0]        null_count = '0;
  logic [WORD_W-1:0]        value_word = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SEC_W-1:0]  epoch_seconds;
  logic [US_W-1:0]          micros;
  logic [CNT_W-1:0]         repeat_count;
  logic [SLOT_W-1:0]        first_slot;
  logic                     record_done;
  logic [ERR_W-1:0]         error_code;

  // Shadow decoder state, advanced once per accepted transaction.
  logic [LVL_W-1:0]  dec_level = LVL_DAYS;
  logic [SEC_W-1:0]  dec_secs = '0;
  logic [US_W-1:0]   dec_usec = '0;
  logic [SLOT_W-1:0] dec_slot = '0;
  logic [SLOT_W-1:0] dec_len = '0;

  stamp_t pending_stamps[$];
  int     mismatch_count = 0;
  int     items_sent = 0;    // transactions accepted so far
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_left = 0;     // cycles of forced receiver hold-off still to run
  event   hold_go;

  timestamp_delta_decoder #(.MAX_SLOTS(MAX_SLOTS)) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .start_us       (start_us),
    .total_length   (total_length),
    .null_count     (null_count),
    .value_word     (value_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .epoch_seconds  (epoch_seconds),
    .micros         (micros),
    .repeat_count   (repeat_count),
    .first_slot     (first_slot),
    .record_done    (record_done),
    .error_code     (error_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run at full stall rates.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Decoder model. Returns 1 when the transaction produces a timestamp.
  // ---------------------------------------------------------------------
  function automatic bit decode_item(input logic cmd, input logic [TS_W-1:0] ts,
                                     input logic [SLOT_W-1:0] len,
                                     input logic [SLOT_W-1:0] nulls,
                                     input logic [WORD_W-1:0] word,
                                     output stamp_t res);
    longint            stamp;
    longint            whole;
    longint            frac;
    logic [DELTA_W-1:0] delta;
    logic [CNT_W-1:0]   cnt;
    logic [US_W:0]      usec_sum;
    logic [SLOT_W-1:0]  first;
    res = '0;
    if (cmd == CMD_START) begin
      // Floor-split the signed start time: the microsecond part is never negative.
      stamp = ts;
      whole = stamp / USEC_PER_SEC;
      frac  = stamp % USEC_PER_SEC;
      if (frac < 0) begin
        frac  += USEC_PER_SEC;
        whole -= 1;
      end
      dec_secs  = SEC_W'(whole);
      dec_usec  = US_W'(frac);
      dec_len   = (len > MAX_SLOTS) ? SLOT_W'(MAX_SLOTS) : len;
      dec_slot  = nulls;
      dec_level = LVL_DAYS;
      return 1'b0;
    end

    // Record finished (or never started): drop the word.
    if (dec_slot >= dec_len) return 1'b0;

    delta = word[WORD_W-1:CNT_W];
    cnt   = word[CNT_W-1:0];
    case (dec_level)
      LVL_DAYS: dec_secs = dec_secs + delta * SECS_PER_DAY;
      LVL_SECS: dec_secs = dec_secs + delta;
      default: begin
        // Wrap to 30 bits first, then at most one carry into the seconds.
        usec_sum = dec_usec + delta;
        dec_usec = usec_sum[US_W-1:0];
        if (dec_usec >= US_PER_SEC) begin
          dec_usec = dec_usec - US_PER_SEC;
          dec_secs = dec_secs + 1'b1;
        end
      end
    endcase

    first = dec_slot;
    if (cnt != 0) begin
      res.err = ERR_NONE;
      if ((SLOT_W+1)'(dec_slot) + cnt > (SLOT_W+1)'(dec_len)) begin
        res.err  = ERR_OVERRUN;
        dec_slot = dec_len;
      end else begin
        dec_slot = dec_slot + cnt;
      end
      dec_level = LVL_DAYS;
      res.reps  = cnt;
    end else if (dec_level == LVL_US) begin
      // Zero count at the finest level ends the record with an error.
      dec_slot  = dec_len;
      dec_level = LVL_DAYS;
      res.reps  = '0;
      res.err   = ERR_ZERO_US;
    end else begin
      dec_level = dec_level + 1'b1;
      return 1'b0;
    end
    res.secs  = dec_secs;
    res.usec  = dec_usec;
    res.first = first;
    res.done  = (dec_slot >= dec_len);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: idle at random, offer one transaction, hold it until accepted.
  // Valid is lowered only by the idle loop or at the very end, so it never
  // sees two nonblocking writes in one step.
  // ---------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [TS_W-1:0] ts,
                           input logic [SLOT_W-1:0] len, input logic [SLOT_W-1:0] nulls,
                           input logic [WORD_W-1:0] word);
    stamp_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    start_us        <= ts;
    total_length    <= len;
    null_count      <= nulls;
    value_word      <= word;
    do @(posedge clk); while (in_stall);
    // Accepted at this edge: advance the model.
    items_sent++;
    if (decode_item(cmd, ts, len, nulls, word, res)) pending_stamps.push_back(res);
  endtask

  // Unused fields carry junk so that the block is seen to ignore them.
  task automatic start_record(input logic [TS_W-1:0] ts, input logic [SLOT_W-1:0] len,
                              input logic [SLOT_W-1:0] nulls);
    send_item(CMD_START, ts, len, nulls, $urandom);
  endtask

  task automatic send_word(input logic [WORD_W-1:0] word);
    send_item(CMD_WORD, {$urandom, $urandom}, SLOT_W'($urandom), SLOT_W'($urandom), word);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus a forced hold-off while hold_left runs.
  // ---------------------------------------------------------------------
  initial begin : hold_counter
    forever begin
      @(hold_go);
      hold_left <= HOLD_CYCLES;
      @(posedge clk);
      while (hold_left > 0) begin
        hold_left <= hold_left - 1;
        @(posedge clk);
      end
    end
  end

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : result_monitor
    stamp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stamps.size() == 0) begin
        note_mismatch("timestamp with nothing outstanding");
      end else begin
        want = pending_stamps.pop_front();
        check_field("epoch_seconds", SEC_W'(epoch_seconds), SEC_W'(want.secs));
        check_field("micros", micros, want.usec);
        check_field("repeat_count", repeat_count, want.reps);
        check_field("first_slot", first_slot, want.first);
        check_field("record_done", record_done, want.done);
        check_field("error_code", error_code, want.err);
      end
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Deltas: zero, full 28-bit, or a size that suits the current level.
  function automatic logic [DELTA_W-1:0] pick_delta(input logic [LVL_W-1:0] lvl);
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) return '0;
    if (pick < 5) return DELTA_W'($urandom);
    case (lvl)
      LVL_DAYS: return DELTA_W'($urandom_range(0, 400));
      LVL_SECS: return DELTA_W'($urandom_range(0, 86399));
      default:  return DELTA_W'($urandom_range(0, 1999999));
    endcase
  endfunction

  function automatic logic [TS_W-1:0] pick_start();
    int                pick;
    logic [39:0]       near;
    pick = $urandom_range(99);
    near = {$urandom, $urandom};
    if (pick < 40) return {$urandom, $urandom};
    if (pick < 70) return {{24{near[39]}}, near};        // around the epoch, either sign
    return 64'd1_700_000_000_000_000 + {$urandom, $urandom} % 64'd100_000_000_000_000;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return SLOT_W'($urandom_range(1, 40));
    if (pick < 80) return SLOT_W'($urandom_range(41, 600));
    if (pick < 85) return '0;
    if (pick < 95) return SLOT_W'($urandom);
    return SLOT_W'($urandom_range(MAX_SLOTS, (1 << SLOT_W) - 1));
  endfunction

  // One record: a start, then mostly well-formed cascades with random
  // content, some broken words, some errors, and noise once it is done.
  task automatic send_random_record();
    logic [SLOT_W-1:0] len;
    logic [SLOT_W-1:0] nulls;
    int                pick;
    int                nwords;
    int                depth;
    len = pick_length();
    pick = $urandom_range(99);
    if (pick < 70) nulls = '0;
    else if (pick < 90) nulls = SLOT_W'($urandom_range(0, int'(len)));
    else nulls = SLOT_W'($urandom);
    start_record(pick_start(), len, nulls);
    nwords = $urandom_range(1, 40);
    for (int i = 0; i < nwords; i++) begin
      if (dec_slot >= dec_len) begin
        if ($urandom_range(2) == 0) send_word($urandom);   // ignored after the end
        break;
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_word($urandom);
      end else begin
        depth = $urandom_range(0, 2);
        repeat (depth) send_word({pick_delta(dec_level), CNT_W'(0)});
        if (dec_level == LVL_US && $urandom_range(99) < 7)
          send_word({pick_delta(dec_level), CNT_W'(0)});
        else if ($urandom_range(3) == 0)
          send_word({pick_delta(dec_level), CNT_W'($urandom_range(1, 15))});
        else
          send_word({pick_delta(dec_level), CNT_W'($urandom_range(1, 3))});
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Nothing has been started after reset, so a word must be dropped.
  task automatic test_word_before_start();
    send_word('1);
  endtask

  // Extreme start times, saturated length, full deltas through the cascade
  // and the zero-count error at the microsecond level.
  task automatic test_start_extremes();
    start_record({1'b1, 63'd0}, 21'd4, '0);
    send_word({{DELTA_W{1'b1}}, CNT_W'(0)});
    send_word({{DELTA_W{1'b1}}, CNT_W'(0)});
    send_word({{DELTA_W{1'b1}}, CNT_W'(0)});
    start_record({1'b0, {63{1'b1}}}, '1, '0);
    send_word({DELTA_W'(1), CNT_W'(15)});
  endtask

  // Microsecond carry into the seconds, once to a clean value and once
  // leaving the microsecond part above a whole second.
  task automatic test_micro_carry();
    start_record(64'd999_999, 21'd8, '0);
    send_word({DELTA_W'(0), CNT_W'(0)});
    send_word({DELTA_W'(0), CNT_W'(0)});
    send_word({DELTA_W'(1), CNT_W'(1)});
    send_word({DELTA_W'(0), CNT_W'(0)});
    send_word({DELTA_W'(0), CNT_W'(0)});
    send_word({{DELTA_W{1'b1}}, CNT_W'(2)});
  endtask

  // Repeat count running past the record length.
  task automatic test_overrun();
    start_record('0, 21'd3, '0);
    send_word({DELTA_W'(7), CNT_W'(15)});
  endtask

  // Null prefix covering the whole record, then one leaving a single slot;
  // a start of -1 us also checks the floored split.
  task automatic test_null_prefix();
    start_record('1, 21'd10, '1);
    send_word({DELTA_W'(3), CNT_W'(1)});
    start_record('1, 21'd5, 21'd4);
    send_word({DELTA_W'(2), CNT_W'(1)});
  endtask

  // A start in the middle of a cascade restarts at the days level.
  task automatic test_abort();
    start_record(64'd5_000_000, 21'd10, '0);
    send_word({DELTA_W'(1), CNT_W'(0)});
    start_record(64'd123_456_789, 21'd2, '0);
    send_word({DELTA_W'(1), CNT_W'(1)});
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so the
  // queue fills and the input is stalled.
  task automatic test_back_pressure();
    start_record(64'd1_000_000, 21'd1000, '0);
    -> hold_go;
    repeat (60) send_word({DELTA_W'($urandom_range(0, 3)), CNT_W'(1)});
  endtask

  task automatic test_random_records(input int goal);
    while (items_sent < goal) send_random_record();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase one: the sender idles a third of the time, the receiver mostly stalls.
    send_idle_pct = 32;
    recv_idle_pct = 70;
    test_word_before_start();
    test_start_extremes();
    test_micro_carry();
    test_overrun();
    test_null_prefix();
    test_abort();
    test_back_pressure();
    test_random_records(350);

    // Phase two: swap the roles.
    send_idle_pct = 70;
    recv_idle_pct = 32;
    test_random_records(600);

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_records(800);
    in_valid <= 1'b0;

    // Drain, then give stray results time to show.
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/tsd_pkg.sv
design/tsd_front.sv
design/tsd_fifo.sv
design/tsd_div.sv
design/tsd_back.sv
design/timestamp_delta_decoder.sv
tb/sv/tb_timestamp_delta_decoder.sv
